// File: rtl/fsss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_pkg: shared types and constants
// Widths, codes and state encoding for the same-sign binary32 subtractor.
// ----------------------------------------------------------------------------
package fsss_pkg;
    localparam int FRACTION_BITS = 23;
    localparam int GUARD_BITS    = 6;
    localparam int EXP_BITS      = 8;
    localparam int WORD_BITS     = 32;
    localparam int SIG_BITS      = FRACTION_BITS + GUARD_BITS + 2;
    localparam logic [EXP_BITS-1:0]  EXP_MAX     = '1;
    localparam logic [WORD_BITS-1:0] DEFAULT_NAN = 32'h7FC0_0001;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_norm_ctl;
endpackage
`default_nettype wire

// File: rtl/fsss_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_norm: normalize shifter
// Holds significand and exponent; shifts left one bit per step.
// ----------------------------------------------------------------------------
module fsss_norm
    import fsss_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_norm_ctl           i_ctl,
    input  wire logic [SIG_BITS-1:0] i_sig,
    input  wire logic [EXP_BITS-1:0] i_exp,
    output logic [SIG_BITS-1:0]      o_sig,
    output logic [EXP_BITS-1:0]      o_exp,
    output logic                     o_done
);
    logic [SIG_BITS-1:0] r_sig, n_sig;
    logic [EXP_BITS-1:0] r_exp, n_exp;

    assign o_done = (r_exp == '0) || r_sig[FRACTION_BITS+GUARD_BITS];

    always_comb begin
        n_sig = r_sig;
        n_exp = r_exp;
        if (i_ctl.load) begin
            n_sig = i_sig;
            n_exp = i_exp;
        end else if (i_ctl.step && !o_done) begin
            n_sig = {r_sig[SIG_BITS-2:0], 1'b0};
            n_exp = r_exp - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sig <= n_sig;
        r_exp <= n_exp;
    end

    assign o_sig = r_sig;
    assign o_exp = r_exp;
endmodule
`default_nettype wire

// File: rtl/float32_same_sign_subtract_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float32_same_sign_subtract_top: binary32 a - b for same-sign operands
// Orders, aligns and subtracts, normalizes one bit per cycle, rounds.
//
//   channel  | handshake            | payload
//   request  | i_start / o_busy     | i_operand_a, i_operand_b
//   result   | o_valid (one cycle)  | o_difference
//
// Special operands and denormal pairs skip normalization; their result is registered straight from idle.
// Others go through ST_NORM, where the one-bit-per-cycle normalize shifter makes 0..254 shifts
// (stopping at the leading one or when the exponent reaches zero), then through ST_ROUND.
// Synchronous active-low reset returns the sequencer to idle.
// The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
module float32_same_sign_subtract_top
    import fsss_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_operand_a,
    input  wire logic [WORD_BITS-1:0] i_operand_b,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic [WORD_BITS-1:0]      o_difference
);
    t_state r_state, n_state;
    logic r_valid, n_valid;
    logic [WORD_BITS-1:0] r_diff, n_diff;
    logic r_sign, n_sign;
    t_norm_ctl ctl;

    logic sa;
    logic [EXP_BITS-1:0] ea, eb, e1, e2, d, d2;
    logic [FRACTION_BITS-1:0] fa, fb, f1, f2;
    logic b_big, sign;
    logic [SIG_BITS-1:0] s1, s2, sub;
    logic [SIG_BITS-1:0] nsig, rnd;
    logic [EXP_BITS-1:0] nexp, rexp;
    logic ndone;

    always_comb begin
        sa = i_operand_a[WORD_BITS-1];
        ea = i_operand_a[WORD_BITS-2:FRACTION_BITS];
        eb = i_operand_b[WORD_BITS-2:FRACTION_BITS];
        fa = i_operand_a[FRACTION_BITS-1:0];
        fb = i_operand_b[FRACTION_BITS-1:0];
        b_big = (eb > ea) || (eb == ea && fb > fa);
        sign = b_big ? ~sa : sa;
        e1 = b_big ? eb : ea;
        e2 = b_big ? ea : eb;
        f1 = b_big ? fb : fa;
        f2 = b_big ? fa : fb;
        d  = e1 - e2;
        d2 = (e2 == '0) ? d - 1'b1 : d;
        s1 = {2'b01, f1, {GUARD_BITS{1'b0}}};
        s2 = {1'b0, (e2 != '0), f2, {GUARD_BITS{1'b0}}};
        if (d2 <= EXP_BITS'(FRACTION_BITS + 1))
            sub = s1 - (s2 >> d2);
        else
            sub = s1;
    end

    fsss_norm u_norm (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_sig  (sub),
        .i_exp  (e1),
        .o_sig  (nsig),
        .o_exp  (nexp),
        .o_done (ndone)
    );

    always_comb begin
        rnd  = nsig + SIG_BITS'(1 << (GUARD_BITS - 1));
        rexp = nexp;
        if (rnd[FRACTION_BITS+GUARD_BITS+1]) begin
            rnd  = rnd >> 1;
            rexp = nexp + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_diff  = r_diff;
        n_sign  = r_sign;
        ctl     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_sign = sign;
                    if (b_big && eb == EXP_MAX) begin
                        n_valid = 1'b1;
                        n_diff  = (fb != '0) ? i_operand_b
                                             : {~i_operand_b[WORD_BITS-1],
                                                i_operand_b[WORD_BITS-2:0]};
                    end else if (!b_big && ea == EXP_MAX) begin
                        n_valid = 1'b1;
                        n_diff  = (fa == '0 && eb == EXP_MAX) ? DEFAULT_NAN
                                                               : i_operand_a;
                    end else if (e1 == '0) begin
                        n_valid = 1'b1;
                        n_diff  = {sign, {EXP_BITS{1'b0}}, f1 - f2};
                    end else begin
                        ctl.load = 1'b1;
                        n_state  = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                ctl.step = 1'b1;
                if (ndone) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_valid = 1'b1;
                n_diff  = {r_sign, rexp, rnd[GUARD_BITS +: FRACTION_BITS]};
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_diff <= n_diff;
        r_sign <= n_sign;
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_difference = r_diff;

`ifndef NO_ASSERTIONS
    a_no_valid_mid_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM) |-> !r_valid)
        else $error("result strobe during normalize");
    a_round_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |=> (r_valid && r_state == ST_IDLE))
        else $error("round did not produce a result");
    a_norm_exits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM && ndone) |=> (r_state == ST_ROUND))
        else $error("normalize did not exit when done");
`endif
endmodule
`default_nettype wire

// File: verif/float32_same_sign_subtract_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_same_sign_subtract_top_tb: self-checking bench for a - b
// Drives binary32 operand pairs through the start/busy request port, predicts
// each difference in the bench and compares it with every o_valid strobe.
// ----------------------------------------------------------------------------
module float32_same_sign_subtract_top_tb
    import fsss_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1830;
    localparam logic [31:0] NO_CHECK = 32'h0;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic        typed;
        logic [31:0] diff;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_busy;
    logic        o_valid;
    logic [31:0] o_difference;

    logic [31:0] pending_diffs[$];
    int          fail_count;
    int          idle_cycles;

    float32_same_sign_subtract_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_busy      (o_busy),
        .o_valid     (o_valid),
        .o_difference(o_difference)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sub_same_sign(logic [31:0] a, logic [31:0] b);
        logic [7:0]  ea, eb;
        logic [22:0] fa, fb;
        logic        sgn, b_big;
        logic [31:0] e1, e2, f1, f2, align;
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        b_big = (eb > ea) || (eb == ea && fb > fa);
        if (b_big) begin
            if (eb == EXP_MAX)
                return (fb != 0) ? b : {~b[31], b[30:0]};
            sgn = ~a[31];
            e1 = 32'(eb); f1 = 32'(fb); e2 = 32'(ea); f2 = 32'(fa);
            align = 32'(eb - ea);
        end else begin
            if (ea == EXP_MAX)
                return (fa == 0 && eb == EXP_MAX) ? DEFAULT_NAN : a;
            sgn = a[31];
            e1 = 32'(ea); f1 = 32'(fa); e2 = 32'(eb); f2 = 32'(fb);
            align = 32'(ea - eb);
        end
        if (e1 == 0) begin
            f1 = f1 - f2;
            return {sgn, 8'd0, f1[22:0]};
        end
        f1 = f1 | (32'd1 << FRACTION_BITS);
        if (e2 == 0)
            align = align - 32'd1;
        else
            f2 = f2 | (32'd1 << FRACTION_BITS);
        f1 = f1 << GUARD_BITS;
        f2 = f2 << GUARD_BITS;
        if (align <= 32'(FRACTION_BITS + 1))
            f1 = f1 - (f2 >> align);
        while (e1 > 0 && f1[FRACTION_BITS+GUARD_BITS] == 1'b0) begin
            e1 = e1 - 32'd1;
            f1 = f1 << 1;
        end
        f1 = f1 + (32'd1 << (GUARD_BITS - 1));
        if (f1[FRACTION_BITS+GUARD_BITS+1]) begin
            e1 = e1 + 32'd1;
            f1 = f1 >> 1;
        end
        return {sgn, e1[7:0], f1[FRACTION_BITS+GUARD_BITS-1:GUARD_BITS]};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // compare each strobe against the oldest pending difference
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_diffs.size() == 0) begin
                report_mismatch("unexpected result", o_difference, NO_CHECK);
            end else begin
                if (o_difference !== pending_diffs[0])
                    report_mismatch("difference", o_difference, pending_diffs[0]);
                void'(pending_diffs.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand(logic sgn);
        logic [7:0]  e;
        logic [22:0] f;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)       e = 8'd0;
        else if (pick < 14) e = 8'hFF;
        else if (pick < 20) e = 8'hFE;
        else                e = 8'($urandom_range(1, 254));
        pick = $urandom_range(0, 9);
        if (pick == 0)      f = '0;
        else if (pick == 1) f = '1;
        else if (pick == 2) f = 23'd1 << $urandom_range(0, 22);
        else                f = 23'($urandom);
        return {sgn, e, f};
    endfunction

    function automatic logic [31:0] near_operand(logic [31:0] a);
        logic [31:0] b;
        int          pick;
        b = a;
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            b[22:0] = a[22:0] ^ (23'd1 << $urandom_range(0, 22));
        end else if (pick == 1) begin
            b[30:23] = a[30:23] - 8'($urandom_range(0, 2));
            b[22:0]  = 23'($urandom);
        end else if (pick == 2) begin
            b[30:23] = a[30:23] + 8'($urandom_range(0, 1));
            b[22:0]  = a[22:0] - 23'($urandom_range(0, 3));
        end else begin
            b[30:23] = a[30:23] - 8'($urandom_range(20, 30));
            b[22:0]  = 23'($urandom);
        end
        return b;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0) begin
            i_start     <= 1'b0;
            i_operand_a <= $urandom;
            i_operand_b <= $urandom;
        end
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_request(logic [31:0] a, logic [31:0] b);
        i_start     <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_diffs.push_back(sub_same_sign(a, b));
    endtask

    t_row directed[] = '{
        '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000},
        '{32'hBF80_0000, 32'hBF80_0000, 1'b1, 32'h8000_0000},
        '{32'h7F80_0000, 32'h7F80_0000, 1'b1, DEFAULT_NAN},
        '{32'hFF80_0000, 32'hFF80_0000, 1'b1, DEFAULT_NAN},
        '{32'h7F80_0000, 32'h3F80_0000, 1'b1, 32'h7F80_0000},
        '{32'h3F80_0000, 32'h7F80_0000, 1'b1, 32'hFF80_0000},
        '{32'h7F80_0001, 32'h7FC0_0000, 1'b1, 32'h7FC0_0000},
        '{32'h7FFF_FFFF, 32'h7F80_0000, 1'b1, 32'h7FFF_FFFF},
        '{32'h3F80_0000, 32'h7F80_0005, 1'b1, 32'h7F80_0005},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h0000_0005, 32'h0000_0003, 1'b1, 32'h0000_0002},
        '{32'h0000_0003, 32'h0000_0005, 1'b1, 32'h8000_0002},
        '{32'h807F_FFFF, 32'h8000_0001, 1'b1, 32'h807F_FFFE},
        '{32'h4000_0000, 32'h3F80_0000, 1'b1, 32'h3F80_0000},
        '{32'h7F7F_FFFF, 32'h0000_0001, 1'b0, NO_CHECK},
        '{32'h7F7F_FFFF, 32'h7F7F_FFFE, 1'b0, NO_CHECK},
        '{32'h0080_0000, 32'h007F_FFFF, 1'b0, NO_CHECK},
        '{32'h0080_0001, 32'h0080_0000, 1'b0, NO_CHECK},
        '{32'h4B80_0000, 32'h3F80_0000, 1'b0, NO_CHECK},
        '{32'h4C80_0000, 32'h3F80_0000, 1'b0, NO_CHECK},
        '{32'h3F7F_FFFF, 32'h3300_0001, 1'b0, NO_CHECK},
        '{32'h7F7F_FFFF, 32'h7300_0000, 1'b0, NO_CHECK},
        '{32'h3F80_0000, 32'hBF80_0000, 1'b0, NO_CHECK},
        '{32'hC000_0000, 32'h3F80_0001, 1'b0, NO_CHECK}
    };

    initial begin
        logic [31:0] a, b;
        int          k;
        fail_count  = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[j]) begin
            if (directed[j].typed &&
                sub_same_sign(directed[j].a, directed[j].b) !== directed[j].diff)
                report_mismatch("table row", sub_same_sign(directed[j].a, directed[j].b),
                                directed[j].diff);
            send_request(directed[j].a, directed[j].b);
            idle_gap();
        end
        for (k = 0; k < N_RANDOM; k++) begin
            a = rand_operand(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 19) == 0)
                b = $urandom;
            else if ($urandom_range(0, 1) == 0)
                b = near_operand(a);
            else
                b = rand_operand(a[31]);
            send_request(a, b);
            if (k % 3 != 0 || k > N_RANDOM / 2)
                idle_gap();
        end
        i_start <= 1'b0;
        while (pending_diffs.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
